### rtl/core/mhtq_pkg.sv
// Shared constants, codes and control types of the min-heap timer queue.
package mhtq_pkg;

  // Default sizes
  localparam int unsigned MHTQ_DEPTH       = 64;
  localparam int unsigned MHTQ_TIME_BITS   = 32;
  localparam int unsigned MHTQ_ID_BITS     = 12;

  // Most expiries one tick may pop
  localparam int unsigned MHTQ_MAX_RESULTS = 64;

  localparam int unsigned MHTQ_STATUS_W    = 3;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } mhtq_op_t;

  typedef enum logic [MHTQ_STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EXPIRED   = 3'd3,
    ST_NONE      = 3'd4
  } mhtq_status_t;

  // Per-level control from the sequencer
  typedef struct packed {
    logic wr_en;     // write this level at the broadcast offset
    logic scan_clr;  // drop the previous id search result
    logic scan_en;   // the broadcast read offsets are a search row
  } mhtq_lvl_ctl_t;

endpackage

### rtl/core/mhtq_level.sv
// One heap level: slot storage, two registered read ports and an id search.
module mhtq_level
  import mhtq_pkg::*;
#(
  parameter int unsigned LVL       = 0,
  parameter int unsigned DEPTH     = MHTQ_DEPTH,
  parameter int unsigned TIME_BITS = MHTQ_TIME_BITS,
  parameter int unsigned ID_BITS   = MHTQ_ID_BITS,
  parameter int unsigned OFW       = 1,
  parameter int unsigned CW        = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mhtq_lvl_ctl_t        ctl,
  input  logic [OFW-1:0]       rd_off_a,
  input  logic [OFW-1:0]       rd_off_b,
  input  logic [OFW-1:0]       wr_off,
  input  logic [TIME_BITS-1:0] wr_key,
  input  logic [ID_BITS-1:0]   wr_id,
  input  logic [ID_BITS-1:0]   scan_id,
  input  logic [CW-1:0]        count,
  output logic [TIME_BITS-1:0] rd_key_a,
  output logic [ID_BITS-1:0]   rd_id_a,
  output logic [TIME_BITS-1:0] rd_key_b,
  output logic [ID_BITS-1:0]   rd_id_b,
  output logic                 hit,
  output logic [OFW-1:0]       hit_off
);

  // First global slot index of this level and the slots it really holds
  localparam int unsigned BASE  = (1 << LVL) - 1;
  localparam int unsigned SPAN  = 1 << LVL;
  localparam int unsigned SLOTS = (SPAN < DEPTH - BASE) ? SPAN : DEPTH - BASE;
  localparam int unsigned AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [TIME_BITS-1:0] key_mem [SLOTS];
  logic [ID_BITS-1:0]   id_mem  [SLOTS];

  logic [TIME_BITS-1:0] rd_key_a_r, rd_key_b_r;
  logic [ID_BITS-1:0]   rd_id_a_r, rd_id_b_r;
  logic [OFW-1:0]       off_a_r, off_b_r;
  logic                 chk_r;
  logic                 hit_r, hit_nxt;
  logic [OFW-1:0]       hit_off_r, hit_off_nxt;
  logic [CW:0]          gidx_a, gidx_b;
  logic                 match_a, match_b;

  // Slot storage, one write and two reads a cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      key_mem[wr_off[AW-1:0]] <= wr_key;
      id_mem[wr_off[AW-1:0]]  <= wr_id;
    end
    rd_key_a_r <= key_mem[rd_off_a[AW-1:0]];
    rd_id_a_r  <= id_mem[rd_off_a[AW-1:0]];
    rd_key_b_r <= key_mem[rd_off_b[AW-1:0]];
    rd_id_b_r  <= id_mem[rd_off_b[AW-1:0]];
    off_a_r    <= rd_off_a;
    off_b_r    <= rd_off_b;
  end

  // Search: a slot counts only while it lies in this level and below the fill count
  assign gidx_a  = (CW+1)'(BASE) + (CW+1)'(off_a_r);
  assign gidx_b  = (CW+1)'(BASE) + (CW+1)'(off_b_r);
  assign match_a = ((CW+1)'(off_a_r) < (CW+1)'(SLOTS)) && (gidx_a < {1'b0, count}) &&
                   (rd_id_a_r == scan_id);
  assign match_b = ((CW+1)'(off_b_r) < (CW+1)'(SLOTS)) && (gidx_b < {1'b0, count}) &&
                   (rd_id_b_r == scan_id);

  // Keep the lowest offset that matches; rows arrive in ascending order
  always_comb begin
    hit_nxt     = hit_r;
    hit_off_nxt = hit_off_r;
    if (ctl.scan_clr) begin
      hit_nxt = 1'b0;
    end else if (chk_r && !hit_r) begin
      if (match_a) begin
        hit_nxt     = 1'b1;
        hit_off_nxt = off_a_r;
      end else if (match_b) begin
        hit_nxt     = 1'b1;
        hit_off_nxt = off_b_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r <= 1'b0;
      hit_r <= 1'b0;
    end else begin
      chk_r <= ctl.scan_en;
      hit_r <= hit_nxt;
    end
    hit_off_r <= hit_off_nxt;
  end

  assign rd_key_a = rd_key_a_r;
  assign rd_id_a  = rd_id_a_r;
  assign rd_key_b = rd_key_b_r;
  assign rd_id_b  = rd_id_b_r;
  assign hit      = hit_r;
  assign hit_off  = hit_off_r;

endmodule

### rtl/core/min_heap_timer_queue.sv
// Top level of the min-heap timer queue: level chain and operation sequencer.
//
// Binary min-heap of timers keyed by expiry, held as a chain of level cells,
// one per heap level, each with its own slot storage. A command is taken when
// start is high and busy is low; every result word is shown for one cycle with
// strobe high and cannot be held off. Each sift step moves one level: it reads
// the neighbouring level, then compares and writes. Adjust and delete first
// search every level in parallel, two slots per level a cycle, then sift. Each
// timer popped by a tick costs one result word, the final word of a command
// carrying out_last.
module min_heap_timer_queue
  import mhtq_pkg::*;
#(
  parameter int unsigned DEPTH     = MHTQ_DEPTH,
  parameter int unsigned TIME_BITS = MHTQ_TIME_BITS,
  parameter int unsigned ID_BITS   = MHTQ_ID_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [1:0]               in_opcode,
  input  logic [ID_BITS-1:0]       in_timer_id,
  input  logic [TIME_BITS-1:0]     in_expire_time,
  input  logic [TIME_BITS-1:0]     in_current_time,
  output logic                     strobe,
  output logic [MHTQ_STATUS_W-1:0] out_status,
  output logic [ID_BITS-1:0]       out_expired_id,
  output logic [TIME_BITS-1:0]     out_expired_at,
  output logic                     out_last
);

  localparam int unsigned L    = $clog2(DEPTH + 1);   // heap levels
  localparam int unsigned CW   = L;                   // fill count width
  localparam int unsigned LW   = (L > 1) ? $clog2(L) : 1;
  localparam int unsigned OFW  = (L > 1) ? L - 1 : 1; // offset within a level
  localparam int unsigned TOPS = DEPTH - (1 << (L - 1)) + 1;
  localparam int unsigned MIDS = 1 << (L - 2);
  localparam int unsigned MAXS = (TOPS > MIDS) ? TOPS : MIDS;
  localparam int unsigned ROWS = (MAXS + 1) / 2;      // search rows
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned NW   = $clog2(MHTQ_MAX_RESULTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_W, S_SCAN_END, S_LAST_RD, S_LAST_GET,
    S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_CMP, S_TK_RD, S_TK_CHK
  } state_t;

  state_t               state_r, state_nxt;
  mhtq_op_t             op_r, op_nxt;
  logic [TIME_BITS-1:0] now_r, now_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [LW-1:0]        lv_r, lv_nxt;
  logic [OFW-1:0]       off_r, off_nxt;
  logic [TIME_BITS-1:0] car_key_r, car_key_nxt;
  logic [ID_BITS-1:0]   car_id_r, car_id_nxt;
  logic                 moved_r, moved_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [LW-1:0]        rd_lvl_r, rd_lvl_nxt;
  logic                 right_ok_r, right_ok_nxt;
  logic [CW-1:0]        last_idx_r, last_idx_nxt;
  logic [LW-1:0]        lpos_lv_r, lpos_lv_nxt;
  logic [OFW-1:0]       lpos_off_r, lpos_off_nxt;
  logic [NW-1:0]        n_r, n_nxt;
  logic                 pend_v_r, pend_v_nxt;
  logic [ID_BITS-1:0]   pend_id_r, pend_id_nxt;
  logic [TIME_BITS-1:0] pend_key_r, pend_key_nxt;

  logic                 strobe_r, strobe_nxt;
  mhtq_status_t         status_r, status_nxt;
  logic [ID_BITS-1:0]   exp_id_r, exp_id_nxt;
  logic [TIME_BITS-1:0] exp_at_r, exp_at_nxt;
  logic                 last_r, last_nxt;

  // Broadcast buses to the level chain
  logic [OFW-1:0]       rd_off_a, rd_off_b;
  logic                 wr_en;
  logic [LW-1:0]        wr_lvl;
  logic [OFW-1:0]       wr_off;
  logic [TIME_BITS-1:0] wr_key;
  logic [ID_BITS-1:0]   wr_id;
  logic                 scan_clr, scan_en;

  mhtq_lvl_ctl_t        lvl_ctl    [L];
  logic [TIME_BITS-1:0] lvl_key_a  [L];
  logic [ID_BITS-1:0]   lvl_id_a   [L];
  logic [TIME_BITS-1:0] lvl_key_b  [L];
  logic [ID_BITS-1:0]   lvl_id_b   [L];
  logic [L-1:0]         lvl_hit;
  logic [OFW-1:0]       lvl_hit_off [L];

  logic [TIME_BITS-1:0] sel_key_a, sel_key_b, ch_key;
  logic [ID_BITS-1:0]   sel_id_a, sel_id_b, ch_id;
  logic                 use_b;
  logic                 f_any;
  logic [LW-1:0]        f_lv;
  logic [OFW-1:0]       f_off;
  logic [CW:0]          left_idx;
  logic                 fin, wrap_up;

  // Global slot index of a level and offset
  function automatic logic [CW:0] gidx(input logic [LW-1:0] lv, input logic [OFW-1:0] off);
    return ((CW+1)'(1) << lv) - (CW+1)'(1) + (CW+1)'(off);
  endfunction

  // Level of global slot index p
  function automatic logic [LW-1:0] pos_lvl(input logic [CW-1:0] p);
    logic [CW:0]   q;
    logic [LW-1:0] r;
    q = (CW+1)'(p) + (CW+1)'(1);
    r = '0;
    for (int l = 0; l < L; l++) begin
      if (q >= ((CW+1)'(1) << l)) r = LW'(l);
    end
    return r;
  endfunction

  // Offset of global slot index p within its level
  function automatic logic [OFW-1:0] pos_off(input logic [CW-1:0] p);
    logic [CW:0] q;
    q = (CW+1)'(p) + (CW+1)'(1);
    return OFW'(q - ((CW+1)'(1) << pos_lvl(p)));
  endfunction

  // Level chain
  for (genvar g = 0; g < L; g++) begin : g_lvl
    assign lvl_ctl[g] = '{
      wr_en:    wr_en && (wr_lvl == LW'(g)),
      scan_clr: scan_clr,
      scan_en:  scan_en
    };

    mhtq_level #(
      .LVL       (g),
      .DEPTH     (DEPTH),
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS),
      .OFW       (OFW),
      .CW        (CW)
    ) u_level (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (lvl_ctl[g]),
      .rd_off_a (rd_off_a),
      .rd_off_b (rd_off_b),
      .wr_off   (wr_off),
      .wr_key   (wr_key),
      .wr_id    (wr_id),
      .scan_id  (car_id_r),
      .count    (count_r),
      .rd_key_a (lvl_key_a[g]),
      .rd_id_a  (lvl_id_a[g]),
      .rd_key_b (lvl_key_b[g]),
      .rd_id_b  (lvl_id_b[g]),
      .hit      (lvl_hit[g]),
      .hit_off  (lvl_hit_off[g])
    );
  end

  // Read data of the level addressed last cycle
  assign sel_key_a = lvl_key_a[rd_lvl_r];
  assign sel_id_a  = lvl_id_a[rd_lvl_r];
  assign sel_key_b = lvl_key_b[rd_lvl_r];
  assign sel_id_b  = lvl_id_b[rd_lvl_r];

  // Sift-down child: right only when it exists and is strictly smaller
  assign use_b  = right_ok_r && (sel_key_b < sel_key_a);
  assign ch_key = use_b ? sel_key_b : sel_key_a;
  assign ch_id  = use_b ? sel_id_b  : sel_id_a;

  // Lowest level with a search hit holds the lowest slot index
  always_comb begin
    f_any = 1'b0;
    f_lv  = '0;
    f_off = '0;
    for (int l = L - 1; l >= 0; l--) begin
      if (lvl_hit[l]) begin
        f_any = 1'b1;
        f_lv  = LW'(l);
        f_off = lvl_hit_off[l];
      end
    end
  end

  assign left_idx = (gidx(lv_r, off_r) << 1) + (CW+1)'(1);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    now_nxt      = now_r;
    count_nxt    = count_r;
    lv_nxt       = lv_r;
    off_nxt      = off_r;
    car_key_nxt  = car_key_r;
    car_id_nxt   = car_id_r;
    moved_nxt    = moved_r;
    row_nxt      = row_r;
    rd_lvl_nxt   = rd_lvl_r;
    right_ok_nxt = right_ok_r;
    last_idx_nxt = last_idx_r;
    lpos_lv_nxt  = lpos_lv_r;
    lpos_off_nxt = lpos_off_r;
    n_nxt        = n_r;
    pend_v_nxt   = pend_v_r;
    pend_id_nxt  = pend_id_r;
    pend_key_nxt = pend_key_r;

    strobe_nxt   = 1'b0;
    status_nxt   = ST_DONE;
    exp_id_nxt   = '0;
    exp_at_nxt   = '0;
    last_nxt     = 1'b0;

    rd_off_a     = '0;
    rd_off_b     = '0;
    wr_en        = 1'b0;
    wr_lvl       = lv_r;
    wr_off       = off_r;
    wr_key       = car_key_r;
    wr_id        = car_id_r;
    scan_clr     = 1'b0;
    scan_en      = 1'b0;
    fin          = 1'b0;
    wrap_up      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          op_nxt      = mhtq_op_t'(in_opcode);
          car_key_nxt = in_expire_time;
          car_id_nxt  = in_timer_id;
          now_nxt     = in_current_time;
          moved_nxt   = 1'b0;
          n_nxt       = '0;
          pend_v_nxt  = 1'b0;
          case (mhtq_op_t'(in_opcode))
            OP_ADD: begin
              if (count_r == CW'(DEPTH)) begin
                strobe_nxt = 1'b1;
                status_nxt = ST_FULL;
                last_nxt   = 1'b1;
              end else begin
                lv_nxt    = pos_lvl(count_r);
                off_nxt   = pos_off(count_r);
                count_nxt = count_r + CW'(1);
                state_nxt = S_UP_RD;
              end
            end
            OP_ADJUST, OP_DELETE: begin
              scan_clr  = 1'b1;
              row_nxt   = '0;
              state_nxt = S_SCAN;
            end
            OP_TICK: begin
              state_nxt = S_TK_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // Search all levels, two slots per level a row
      S_SCAN: begin
        scan_en  = 1'b1;
        rd_off_a = OFW'(row_r) << 1;
        rd_off_b = (OFW'(row_r) << 1) | OFW'(1);
        if (row_r == RW'(ROWS - 1)) begin
          state_nxt = S_SCAN_W;
        end else begin
          row_nxt = row_r + RW'(1);
        end
      end

      S_SCAN_W: begin
        state_nxt = S_SCAN_END;
      end

      S_SCAN_END: begin
        if (!f_any) begin
          strobe_nxt = 1'b1;
          status_nxt = ST_NOT_FOUND;
          last_nxt   = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          lv_nxt  = f_lv;
          off_nxt = f_off;
          if (op_r == OP_ADJUST) begin
            state_nxt = S_UP_RD;
          end else begin
            last_idx_nxt = count_r - CW'(1);
            lpos_lv_nxt  = pos_lvl(count_r - CW'(1));
            lpos_off_nxt = pos_off(count_r - CW'(1));
            count_nxt    = count_r - CW'(1);
            state_nxt    = S_LAST_RD;
          end
        end
      end

      // Fetch the last entry to refill the vacated slot
      S_LAST_RD: begin
        rd_lvl_nxt = lpos_lv_r;
        rd_off_a   = lpos_off_r;
        state_nxt  = S_LAST_GET;
      end

      S_LAST_GET: begin
        if (gidx(lv_r, off_r) == {1'b0, last_idx_r}) begin
          fin = 1'b1;
        end else begin
          car_key_nxt = sel_key_a;
          car_id_nxt  = sel_id_a;
          moved_nxt   = 1'b0;
          state_nxt   = S_UP_RD;
        end
      end

      // Sift up: read the parent on the level above
      S_UP_RD: begin
        if (lv_r == '0) begin
          if (moved_r) begin
            wr_en = 1'b1;
            fin   = 1'b1;
          end else begin
            state_nxt = S_DN_RD;
          end
        end else begin
          rd_lvl_nxt = lv_r - LW'(1);
          rd_off_a   = off_r >> 1;
          state_nxt  = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        if (car_key_r < sel_key_a) begin
          wr_en     = 1'b1;
          wr_key    = sel_key_a;
          wr_id     = sel_id_a;
          lv_nxt    = lv_r - LW'(1);
          off_nxt   = off_r >> 1;
          moved_nxt = 1'b1;
          state_nxt = S_UP_RD;
        end else if (moved_r) begin
          wr_en = 1'b1;
          fin   = 1'b1;
        end else begin
          state_nxt = S_DN_RD;
        end
      end

      // Sift down: read both children on the level below
      S_DN_RD: begin
        if (left_idx >= (CW+1)'(count_r)) begin
          wr_en = 1'b1;
          fin   = 1'b1;
        end else begin
          rd_lvl_nxt   = lv_r + LW'(1);
          rd_off_a     = off_r << 1;
          rd_off_b     = (off_r << 1) | OFW'(1);
          right_ok_nxt = (left_idx + (CW+1)'(1)) < (CW+1)'(count_r);
          state_nxt    = S_DN_CMP;
        end
      end

      S_DN_CMP: begin
        if (ch_key < car_key_r) begin
          wr_en     = 1'b1;
          wr_key    = ch_key;
          wr_id     = ch_id;
          lv_nxt    = lv_r + LW'(1);
          off_nxt   = (off_r << 1) | OFW'(use_b);
          state_nxt = S_DN_RD;
        end else begin
          wr_en = 1'b1;
          fin   = 1'b1;
        end
      end

      // Tick: look at the root
      S_TK_RD: begin
        if (count_r == '0 || n_r == NW'(MHTQ_MAX_RESULTS)) begin
          wrap_up = 1'b1;
        end else begin
          rd_lvl_nxt = '0;
          rd_off_a   = '0;
          state_nxt  = S_TK_CHK;
        end
      end

      S_TK_CHK: begin
        if (sel_key_a <= now_r) begin
          if (pend_v_r) begin
            strobe_nxt = 1'b1;
            status_nxt = ST_EXPIRED;
            exp_id_nxt = pend_id_r;
            exp_at_nxt = pend_key_r;
          end
          pend_v_nxt   = 1'b1;
          pend_id_nxt  = sel_id_a;
          pend_key_nxt = sel_key_a;
          n_nxt        = n_r + NW'(1);
          lv_nxt       = '0;
          off_nxt      = '0;
          last_idx_nxt = count_r - CW'(1);
          lpos_lv_nxt  = pos_lvl(count_r - CW'(1));
          lpos_off_nxt = pos_off(count_r - CW'(1));
          count_nxt    = count_r - CW'(1);
          state_nxt    = S_LAST_RD;
        end else begin
          wrap_up = 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Sift finished: a tick goes back to the root, others report done
    if (fin) begin
      if (op_r == OP_TICK) begin
        state_nxt = S_TK_RD;
      end else begin
        strobe_nxt = 1'b1;
        status_nxt = ST_DONE;
        last_nxt   = 1'b1;
        state_nxt  = S_IDLE;
      end
    end

    // End of a tick: flush the held expiry as the final word
    if (wrap_up) begin
      strobe_nxt = 1'b1;
      last_nxt   = 1'b1;
      if (pend_v_r) begin
        status_nxt = ST_EXPIRED;
        exp_id_nxt = pend_id_r;
        exp_at_nxt = pend_key_r;
      end else begin
        status_nxt = ST_NONE;
      end
      pend_v_nxt = 1'b0;
      state_nxt  = S_IDLE;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      count_r  <= '0;
      pend_v_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      pend_v_r <= pend_v_nxt;
      strobe_r <= strobe_nxt;
    end
    op_r       <= op_nxt;
    now_r      <= now_nxt;
    lv_r       <= lv_nxt;
    off_r      <= off_nxt;
    car_key_r  <= car_key_nxt;
    car_id_r   <= car_id_nxt;
    moved_r    <= moved_nxt;
    row_r      <= row_nxt;
    rd_lvl_r   <= rd_lvl_nxt;
    right_ok_r <= right_ok_nxt;
    last_idx_r <= last_idx_nxt;
    lpos_lv_r  <= lpos_lv_nxt;
    lpos_off_r <= lpos_off_nxt;
    n_r        <= n_nxt;
    pend_id_r  <= pend_id_nxt;
    pend_key_r <= pend_key_nxt;
    status_r   <= status_nxt;
    exp_id_r   <= exp_id_nxt;
    exp_at_r   <= exp_at_nxt;
    last_r     <= last_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign strobe         = strobe_r;
  assign out_status     = status_r;
  assign out_expired_id = exp_id_r;
  assign out_expired_at = exp_at_r;
  assign out_last       = last_r;

endmodule
